@@ rtl/assert_macros.svh @@
// assertion macros for the phase reliability block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

@@ rtl/prsd_pkg.sv @@
package prsd_pkg;

    localparam int MAX_ROWS_DEF  = 64;
    localparam int MAX_COLS_DEF  = 64;
    localparam int MAX_PAGES_DEF = 16;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_PAGES = 2'd2;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic               command;
        logic [5:0]         row;
        logic [5:0]         col;
        logic [3:0]         page;
        logic signed [15:0] phase;
    } in_item_t;

    typedef struct packed {
        logic [31:0] reliability;
        logic        on_border;
        logic        saturated;
    } out_item_t;

    // handshake between sequencer and root/divide unit
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } math_ctl_t;

endpackage

@@ rtl/prsd_math.sv @@
`include "assert_macros.svh"

// integer square root of a 36-bit sum, then 2^32 / root, one bit per cycle
module prsd_math (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [35:0]         sum,
    output prsd_pkg::math_ctl_t ctl,
    output logic [31:0]         quotient,
    output logic                saturated
);

    localparam logic [1:0] M_IDLE = 2'd0;
    localparam logic [1:0] M_SQRT = 2'd1;
    localparam logic [1:0] M_DIV  = 2'd2;
    localparam logic [1:0] M_DONE = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [35:0] rem_reg, rem_next;   // sqrt remainder / division remainder
    logic [35:0] val_reg, val_next;   // radicand shifted out two bits a step
    logic [32:0] res_reg, res_next;   // dividend, then quotient bits
    logic [17:0] root_reg, root_next;
    logic        sat_reg, sat_next;

    logic [37:0] trial;
    logic [37:0] rem_sh;
    logic [33:0] drem;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        val_next   = val_reg;
        res_next   = res_reg;
        root_next  = root_reg;
        sat_next   = sat_reg;
        rem_sh     = {rem_reg, val_reg[35:34]};
        trial      = {18'd0, root_reg, 2'b01};
        drem       = {rem_reg[32:0], 1'b0};
        unique case (state_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    state_next = M_SQRT;
                    cnt_next   = 6'd18;
                    rem_next   = '0;
                    val_next   = sum;
                    root_next  = '0;
                end
            end
            M_SQRT:
            begin
                val_next = {val_reg[33:0], 2'b00};
                if (rem_sh >= trial)
                begin
                    rem_next  = 36'(rem_sh - trial);
                    root_next = {root_reg[16:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh[35:0];
                    root_next = {root_reg[16:0], 1'b0};
                end
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    state_next = M_DIV;
                    cnt_next   = 6'd33;
                    // dividend is 1 followed by 32 zeros
                    rem_next   = '0;
                    res_next   = {1'b1, 32'd0};
                end
            end
            M_DIV:
            begin
                sat_next = (root_reg <= 18'd1);
                drem     = {rem_reg[32:0], res_reg[32]};
                if (drem >= {16'd0, root_reg})
                begin
                    rem_next = 36'(drem - {16'd0, root_reg});
                    res_next = {res_reg[31:0], 1'b1};
                end
                else
                begin
                    rem_next = {2'b00, drem};
                    res_next = {res_reg[31:0], 1'b0};
                end
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                    state_next = M_DONE;
            end
            M_DONE:
            begin
                state_next = M_IDLE;
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        val_reg  <= val_next;
        res_reg  <= res_next;
        root_reg <= root_next;
        sat_reg  <= sat_next;
    end

    assign ctl.start = start;
    assign ctl.busy  = (state_reg != M_IDLE);
    assign ctl.done  = (state_reg == M_DONE);
    assign quotient  = sat_reg ? 32'hFFFF_FFFF : res_reg[31:0];
    assign saturated = sat_reg;

    `ASSERT_IMPLIES(a_no_start_busy, clk, rst_n, state_reg != M_IDLE, !start)
    `ASSERT_NEXT(a_start_sqrt, clk, rst_n, start && state_reg == M_IDLE, state_reg == M_SQRT)
    `ASSERT_NEXT(a_done_idle, clk, rst_n, state_reg == M_DONE, state_reg == M_IDLE)

endmodule

@@ rtl/phase_reliability_second_difference_top.sv @@
// phase reliability of one voxel of a stored volume of wrapped phase samples
// input channel: in_valid / in_stall with payload in_item (prsd_pkg::in_item_t)
//   a load request writes one 16-bit sample and returns nothing
//   a query request returns one result on out_valid / out_stall / out_item
// configuration: cfg_we, cfg_index, cfg_data; rows, cols, pages in use
// a load is written on acceptance and loads may follow back to back
// an interior query reads the center and 8 neighbors (18 with page terms),
//   one read per cycle, then runs 18 root and 33 divide steps on one shared
//   unit, and then raises out_valid with the result
// a border or out-of-volume query answers in the cycle after acceptance
// one request at a time: in_stall stays high while a request is at work
// the result sits in an output register until taken; while out_stall is high
//   it holds and no new request is taken
// reset clears control state and sets 64 rows, 64 columns, 1 page;
//   the sample memory is not cleared and must be written before it is read
// the memory is one array with one write and one registered read port
`include "assert_macros.svh"

module phase_reliability_second_difference_top #(
    parameter int MAX_ROWS  = prsd_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS  = prsd_pkg::MAX_COLS_DEF,
    parameter int MAX_PAGES = prsd_pkg::MAX_PAGES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  prsd_pkg::in_item_t              in_item,
    output logic                            out_valid,
    input  logic                            out_stall,
    output prsd_pkg::out_item_t             out_item,
    input  logic                            cfg_we,
    input  logic [prsd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [prsd_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS * MAX_PAGES;
    localparam int AW    = $clog2(DEPTH);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;  // issue reads, one per cycle
    localparam logic [2:0] S_ACC   = 3'd2;  // last read returning
    localparam logic [2:0] S_MATH  = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;
    localparam logic [2:0] S_START = 3'd5;

    // read order: 0 center, then pairs (a, b) for terms 0..8
    localparam int NREAD = 19;

    logic [2:0]  state_reg, state_next;
    logic [4:0]  idx_reg, idx_next;      // read being issued
    logic        rv_reg;                 // read data valid in rdata
    logic [4:0]  ridx_reg;               // index of data in rdata
    logic [6:0]  rows_reg, cols_reg;
    logic [4:0]  pages_reg;
    logic [5:0]  q_row_reg;
    logic [5:0]  q_col_reg;
    logic [3:0]  q_page_reg;
    logic        q_3d_reg;
    logic [15:0] center_reg;
    logic [15:0] a_reg;
    logic [35:0] sum_reg;
    prsd_pkg::out_item_t out_reg;
    logic        out_valid_reg;

    logic [15:0] mem [DEPTH];
    logic [15:0] rdata;
    logic        mem_we;
    logic [AW-1:0] waddr, raddr;

    // clamp a count to 1..max
    function automatic logic [6:0] clamp7(input logic [6:0] v, input int mx);
        logic [6:0] r;
        r = v;
        if (v == 7'd0)
            r = 7'd1;
        else if (32'(v) > mx)
            r = 7'(mx);
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= clamp7(7'd64, MAX_ROWS);
            cols_reg  <= clamp7(7'd64, MAX_COLS);
            pages_reg <= 5'(clamp7(7'd1, MAX_PAGES));
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                prsd_pkg::REG_NUM_ROWS:  rows_reg  <= clamp7(cfg_data, MAX_ROWS);
                prsd_pkg::REG_NUM_COLS:  cols_reg  <= clamp7(cfg_data, MAX_COLS);
                prsd_pkg::REG_NUM_PAGES:
                    pages_reg <= 5'(clamp7({2'b00, cfg_data[4:0]}, MAX_PAGES));
                default: ;
            endcase
        end
    end

    // accept
    logic accept;
    assign in_stall = (state_reg != S_IDLE) || out_valid_reg;
    assign accept   = in_valid && !in_stall;

    // load address check and address build
    logic load_ok;
    assign load_ok = (32'(in_item.row) < MAX_ROWS) && (32'(in_item.col) < MAX_COLS)
                  && (32'(in_item.page) < MAX_PAGES);
    assign mem_we = accept && (in_item.command == prsd_pkg::CMD_LOAD) && load_ok;

    function automatic logic [AW-1:0] addr_of(input logic [6:0] r, input logic [6:0] c,
                                              input logic [4:0] p);
        logic [31:0] a;
        a = (32'(p) * MAX_ROWS + 32'(r)) * MAX_COLS + 32'(c);
        return AW'(a);
    endfunction

    assign waddr = addr_of({1'b0, in_item.row}, {1'b0, in_item.col},
                           {1'b0, in_item.page});

    // neighbor offsets for read index: dr, dc, dp in {-1,0,1}
    logic signed [1:0] dr, dc, dp;
    always_comb
    begin
        dr = 2'sd0; dc = 2'sd0; dp = 2'sd0;
        unique case (idx_reg)
            5'd1:  begin dr = -2'sd1; end
            5'd2:  begin dr =  2'sd1; end
            5'd3:  begin dc = -2'sd1; end
            5'd4:  begin dc =  2'sd1; end
            5'd5:  begin dr = -2'sd1; dc = -2'sd1; end
            5'd6:  begin dr =  2'sd1; dc =  2'sd1; end
            5'd7:  begin dr = -2'sd1; dc =  2'sd1; end
            5'd8:  begin dr =  2'sd1; dc = -2'sd1; end
            5'd9:  begin dp = -2'sd1; end
            5'd10: begin dp =  2'sd1; end
            5'd11: begin dr = -2'sd1; dc = -2'sd1; dp = -2'sd1; end
            5'd12: begin dr =  2'sd1; dc =  2'sd1; dp =  2'sd1; end
            5'd13: begin dr =  2'sd1; dc = -2'sd1; dp = -2'sd1; end
            5'd14: begin dr = -2'sd1; dc =  2'sd1; dp =  2'sd1; end
            5'd15: begin dr = -2'sd1; dc =  2'sd1; dp = -2'sd1; end
            5'd16: begin dr =  2'sd1; dc = -2'sd1; dp =  2'sd1; end
            5'd17: begin dr =  2'sd1; dc =  2'sd1; dp = -2'sd1; end
            5'd18: begin dr = -2'sd1; dc = -2'sd1; dp =  2'sd1; end
            default: ;
        endcase
    end

    assign raddr = addr_of(7'({1'b0, q_row_reg} + 7'(signed'(dr))),
                           7'({1'b0, q_col_reg} + 7'(signed'(dc))),
                           5'({1'b0, q_page_reg} + 5'(signed'(dp))));

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[waddr] <= in_item.phase;
        rdata <= mem[raddr];
    end

    // border test at accept
    logic border;
    assign border = ({1'b0, in_item.row} >= rows_reg) || ({1'b0, in_item.col} >= cols_reg)
                 || ({1'b0, in_item.page} >= pages_reg) || (in_item.row == 6'd0)
                 || (in_item.col == 6'd0)
                 || (7'({1'b0, in_item.row} + 7'd1) >= rows_reg)
                 || (7'({1'b0, in_item.col} + 7'd1) >= cols_reg);

    // one shared wrapped second-difference and square step
    logic [15:0] d1, d2;
    logic signed [17:0] t;
    logic [35:0] t_sq;
    assign d1   = a_reg - center_reg;
    assign d2   = center_reg - rdata;
    assign t    = 18'(signed'(d1)) - 18'(signed'(d2));
    assign t_sq = 36'(t * t);

    // math unit
    logic math_start;
    prsd_pkg::math_ctl_t math_ctl;
    logic [31:0] quot;
    logic        sat;
    assign math_start = (state_reg == S_START);

    prsd_math u_math (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (math_start),
        .sum       (sum_reg),
        .ctl       (math_ctl),
        .quotient  (quot),
        .saturated (sat)
    );

    logic [4:0] last_idx;
    assign last_idx = q_3d_reg ? 5'(NREAD - 1) : 5'd8;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && in_item.command == prsd_pkg::CMD_QUERY && !border)
                begin
                    state_next = S_READ;
                    idx_next   = 5'd0;
                end
            end
            S_READ:
            begin
                idx_next = idx_reg + 5'd1;
                if (idx_reg == last_idx)
                    state_next = S_ACC;
            end
            S_ACC:   state_next = S_START;
            S_START: state_next = S_MATH;
            S_MATH:
            begin
                if (math_ctl.done)
                    state_next = S_OUT;
            end
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            rv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            rv_reg    <= (state_reg == S_READ);
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            else if (state_reg == S_OUT)
                out_valid_reg <= 1'b1;
            else if (accept && in_item.command == prsd_pkg::CMD_QUERY && border)
                out_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        ridx_reg <= idx_reg;
        if (accept)
        begin
            q_row_reg  <= in_item.row;
            q_col_reg  <= in_item.col;
            q_page_reg <= in_item.page;
            q_3d_reg   <= (in_item.page != 4'd0)
                       && (5'({1'b0, in_item.page} + 5'd1) < pages_reg);
            sum_reg    <= '0;
            if (border)
                out_reg <= '{reliability: 32'd0, on_border: 1'b1, saturated: 1'b0};
        end
        if (rv_reg)
        begin
            if (ridx_reg == 5'd0)
                center_reg <= rdata;
            else if (ridx_reg[0])
                a_reg <= rdata;
            else
                sum_reg <= 36'(sum_reg + t_sq);
        end
        if (state_reg == S_OUT)
            out_reg <= '{reliability: quot, on_border: 1'b0, saturated: sat};
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    `ASSERT_IMPLIES(a_busy_stall, clk, rst_n, state_reg != S_IDLE, in_stall)
    `ASSERT_IMPLIES(a_math_in_math, clk, rst_n, math_ctl.busy, state_reg == S_MATH || state_reg == S_OUT)
    `ASSERT_NEXT(a_out_after_math, clk, rst_n, state_reg == S_OUT, out_valid)

endmodule
